[rtl/kvlp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kvlp_pkg
// Shared types and character constants for the key/value line parser.
// ----------------------------------------------------------------------------
package kvlp_pkg;

    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_ONE   = 8'h31;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NUL   = 8'h00;

    localparam logic OP_LINE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // parse phase of the command line
    typedef enum logic [3:0] {
        PH_DONE = 4'b0001,
        PH_GAP  = 4'b0010,
        PH_KEY  = 4'b0100,
        PH_VAL  = 4'b1000
    } t_phase;

    // lookup sequencer
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LEN    = 8'b0000_0010,
        S_LCHK   = 8'b0000_0100,
        S_KRD    = 8'b0000_1000,
        S_KCHK   = 8'b0001_0000,
        S_VRD    = 8'b0010_0000,
        S_VEM    = 8'b0100_0000,
        S_SINGLE = 8'b1000_0000
    } t_lk_state;

endpackage : kvlp_pkg
`default_nettype wire

[rtl/key_value_line_parser_lookup_unit.sv]
`default_nettype none
// Flow: a line byte or a query byte without last_byte is taken without stall;
// a line byte returns nothing. A query with last_byte stalls input while the
// lookup scans entries (length read, length check) and key bytes (read, check)
// and sends each value byte (read, emit; emit waits on output stall), bounded
// by the single read port of the key and value memories.
// Reset: synchronous active low; parse done, table empty, query cleared.
// ----------------------------------------------------------------------------
// key_value_line_parser_lookup_unit
// Tokenizes command-line bytes into a key/value table held in memories and
// answers key queries with the stored value bytes.
// ----------------------------------------------------------------------------
module key_value_line_parser_lookup_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_KEY     = 32,
    parameter int MAX_VALUE   = 64,
    parameter int LINE_BUF    = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_found,
    output logic [7:0]      o_value_byte,
    output logic            o_byte_valid,
    output logic            o_bool_value,
    output logic            o_last_result
);
    import kvlp_pkg::*;

    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int KLW = $clog2(MAX_KEY + 1);
    localparam int QIW = $clog2(MAX_KEY);
    localparam int VLW = $clog2(MAX_VALUE);
    localparam int LBW = (LINE_BUF > 2) ? $clog2(LINE_BUF) : 1;
    localparam int KD  = MAX_ENTRIES * MAX_KEY;
    localparam int VD  = MAX_ENTRIES * MAX_VALUE;
    localparam int KAW = $clog2(KD);
    localparam int VAW = $clog2(VD);

    // memories
    logic [7:0]     key_mem  [KD];
    logic [7:0]     val_mem  [VD];
    logic [KLW-1:0] klen_mem [MAX_ENTRIES];
    logic [VLW-1:0] vlen_mem [MAX_ENTRIES];
    logic [7:0]     qbuf_mem [MAX_KEY];

    // parser state
    t_phase         r_ph;
    logic [KLW-1:0] r_kl;
    logic [VLW-1:0] r_vl;
    logic [EW-1:0]  r_np;
    logic [LBW-1:0] r_lbs;
    logic [KLW-1:0] r_qlen;
    logic           r_qclosed;

    // lookup state
    t_lk_state      r_st;
    logic [EW-1:0]  r_ei;
    logic [KAW-1:0] r_kbase;
    logic [VAW-1:0] r_vbase;
    logic [KLW-1:0] r_j;
    logic [VLW-1:0] r_vj;
    logic           r_hit;
    logic           r_bv;
    logic [7:0]     r_key_q;
    logic [7:0]     r_qb_q;
    logic [7:0]     r_val_q;
    logic [KLW-1:0] r_klen_q;
    logic [VLW-1:0] r_vlen_q;

    // output register
    logic           r_ov;
    logic           r_found;
    logic [7:0]     r_vbyte;
    logic           r_bvld;
    logic           r_bool;
    logic           r_last;

    logic in_acc;
    logic ofree;
    assign o_in_stall = (r_st != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ofree      = !r_ov || !i_out_stall;

    // ---------------- line parse (combinational) ----------------
    t_phase         s_ph, a_ph, cm_ph, n_ph;
    logic [KLW-1:0] s_kl, a_kl, cm_kl, n_kl, k_off;
    logic [VLW-1:0] s_vl, a_vl, cm_vl, n_vl;
    logic [EW-1:0]  s_np, n_np;
    logic [LBW-1:0] s_lbs, n_lbs;
    logic [LBW:0]   lbs_inc;
    logic           is_blank, is_eq, room, cpre, cm_en, line_end;
    logic           kwe, vwe, lwe;
    logic [VLW-1:0] v_off;
    logic [7:0]     v_data;
    logic [KAW-1:0] kw_addr;
    logic [VAW-1:0] vw_addr;

    always_comb begin
        s_ph  = (i_first_byte) ? PH_GAP : r_ph;
        s_kl  = (i_first_byte) ? '0 : r_kl;
        s_vl  = (i_first_byte) ? '0 : r_vl;
        s_np  = (i_first_byte) ? '0 : r_np;
        s_lbs = (i_first_byte) ? '0 : r_lbs;
        is_blank = (i_data_byte == C_SPACE) || (i_data_byte == C_TAB);
        is_eq    = (i_data_byte == C_EQ);
        room     = (s_np < EW'(MAX_ENTRIES));
        a_ph  = s_ph;
        a_kl  = s_kl;
        a_vl  = s_vl;
        k_off = s_kl;
        kwe   = 1'b0;
        vwe   = 1'b0;
        v_off = s_vl;
        v_data = i_data_byte;
        cpre  = 1'b0;
        case (s_ph)
            PH_GAP: begin
                if (!is_blank) begin
                    a_kl = '0;
                    a_vl = '0;
                    if (is_eq) begin
                        a_ph = PH_VAL;
                    end else begin
                        a_ph  = PH_KEY;
                        k_off = '0;
                        kwe   = room;
                        a_kl  = KLW'(1);
                    end
                end
            end
            PH_KEY: begin
                if (is_blank) begin
                    cpre = 1'b1;
                    a_ph = PH_GAP;
                end else if (is_eq) begin
                    a_ph = PH_VAL;
                    a_vl = '0;
                end else if (s_kl < KLW'(MAX_KEY - 1)) begin
                    kwe  = room;
                    a_kl = s_kl + KLW'(1);
                end
            end
            PH_VAL: begin
                if (is_blank) begin
                    cpre = 1'b1;
                    a_ph = PH_GAP;
                end else if (s_vl < VLW'(MAX_VALUE - 1)) begin
                    vwe  = room;
                    a_vl = s_vl + VLW'(1);
                end
            end
            default: begin
            end
        endcase

        lbs_inc  = {1'b0, s_lbs} + (LBW + 1)'(1);
        line_end = i_last_byte || (lbs_inc >= (LBW + 1)'(LINE_BUF - 1));

        // select which state the commit sees
        cm_en = 1'b0;
        cm_ph = a_ph;
        cm_kl = a_kl;
        cm_vl = a_vl;
        n_ph  = r_ph;
        n_kl  = r_kl;
        n_vl  = r_vl;
        n_np  = r_np;
        n_lbs = r_lbs;
        if (in_acc && i_opcode == OP_LINE) begin
            n_ph  = s_ph;
            n_kl  = s_kl;
            n_vl  = s_vl;
            n_np  = s_np;
            n_lbs = s_lbs;
            if (s_ph != PH_DONE) begin
                if (i_data_byte == C_NUL) begin
                    cm_en = 1'b1;
                    cm_ph = s_ph;
                    cm_kl = s_kl;
                    cm_vl = s_vl;
                    kwe   = 1'b0;
                    vwe   = 1'b0;
                    n_ph  = PH_DONE;
                end else begin
                    n_ph  = a_ph;
                    n_kl  = a_kl;
                    n_vl  = a_vl;
                    n_lbs = lbs_inc[LBW-1:0];
                    if (cpre) begin
                        cm_en = 1'b1;
                        cm_ph = s_ph;
                        cm_kl = s_kl;
                        cm_vl = s_vl;
                    end
                    if (line_end) begin
                        n_ph = PH_DONE;
                        if (!cpre) begin
                            cm_en = 1'b1;
                        end
                    end
                end
            end else begin
                kwe = 1'b0;
                vwe = 1'b0;
            end
        end else begin
            kwe = 1'b0;
            vwe = 1'b0;
        end

        lwe = 1'b0;
        if (cm_en) begin
            if (cm_ph == PH_KEY) begin
                // key with no '=' gets value "1"
                cm_vl  = VLW'(1);
                vwe    = room;
                v_off  = '0;
                v_data = C_ONE;
            end
            n_vl = cm_vl;
            if ((cm_ph == PH_KEY || cm_ph == PH_VAL) && cm_kl != '0 && room) begin
                lwe  = 1'b1;
                n_np = s_np + EW'(1);
            end
        end

        kw_addr = KAW'(KAW'(s_np) * KAW'(MAX_KEY) + KAW'(k_off));
        vw_addr = VAW'(VAW'(s_np) * VAW'(MAX_VALUE) + VAW'(v_off));
    end

    // ---------------- query collect ----------------
    logic           q_first_open;
    logic           qwe;
    logic [KLW-1:0] q_base;
    logic [KLW-1:0] n_qlen;
    logic           n_qclosed;
    logic           lk_start;

    always_comb begin
        q_base       = (i_first_byte) ? '0 : r_qlen;
        q_first_open = i_first_byte || !r_qclosed;
        qwe          = 1'b0;
        n_qlen       = r_qlen;
        n_qclosed    = r_qclosed;
        lk_start     = 1'b0;
        if (in_acc && i_opcode == OP_QUERY) begin
            n_qlen    = q_base;
            n_qclosed = (i_first_byte) ? 1'b0 : r_qclosed;
            if (q_first_open) begin
                if (i_data_byte == C_NUL) begin
                    n_qclosed = 1'b1;
                end else if (q_base < KLW'(MAX_KEY - 1)) begin
                    qwe    = 1'b1;
                    n_qlen = q_base + KLW'(1);
                end else begin
                    n_qlen = KLW'(MAX_KEY);
                end
            end
            lk_start = i_last_byte;
        end
    end

    // ---------------- lookup sequencer ----------------
    t_lk_state      n_st;
    logic [EW-1:0]  n_ei;
    logic [KAW-1:0] n_kbase;
    logic [VAW-1:0] n_vbase;
    logic [KLW-1:0] n_j;
    logic [VLW-1:0] n_vj;
    logic           n_hit, n_bv;
    logic           len_re, key_re, val_re;
    logic           o_load;
    logic           ld_found, ld_bvld, ld_bool, ld_last;
    logic [7:0]     ld_byte;

    always_comb begin
        n_st    = r_st;
        n_ei    = r_ei;
        n_kbase = r_kbase;
        n_vbase = r_vbase;
        n_j     = r_j;
        n_vj    = r_vj;
        n_hit   = r_hit;
        n_bv    = r_bv;
        len_re  = 1'b0;
        key_re  = 1'b0;
        val_re  = 1'b0;
        o_load  = 1'b0;
        ld_found = r_hit;
        ld_byte  = '0;
        ld_bvld  = 1'b0;
        ld_bool  = r_hit;
        ld_last  = 1'b1;
        case (r_st)
            S_IDLE: begin
                if (lk_start) begin
                    n_ei    = '0;
                    n_kbase = '0;
                    n_vbase = '0;
                    n_st    = S_LEN;
                end
            end
            S_LEN: begin
                if (r_ei == r_np) begin
                    n_hit = 1'b0;
                    n_st  = S_SINGLE;
                end else begin
                    len_re = 1'b1;
                    n_st   = S_LCHK;
                end
            end
            S_LCHK: begin
                if (r_klen_q == r_qlen) begin
                    n_j  = '0;
                    n_st = S_KRD;
                end else begin
                    n_ei    = r_ei + EW'(1);
                    n_kbase = r_kbase + KAW'(MAX_KEY);
                    n_vbase = r_vbase + VAW'(MAX_VALUE);
                    n_st    = S_LEN;
                end
            end
            S_KRD: begin
                key_re = 1'b1;
                n_st   = S_KCHK;
            end
            S_KCHK: begin
                if (r_key_q != r_qb_q) begin
                    n_ei    = r_ei + EW'(1);
                    n_kbase = r_kbase + KAW'(MAX_KEY);
                    n_vbase = r_vbase + VAW'(MAX_VALUE);
                    n_st    = S_LEN;
                end else if (r_j + KLW'(1) == r_qlen) begin
                    n_hit = 1'b1;
                    n_vj  = '0;
                    n_st  = (r_vlen_q == '0) ? S_SINGLE : S_VRD;
                end else begin
                    n_j  = r_j + KLW'(1);
                    n_st = S_KRD;
                end
            end
            S_VRD: begin
                val_re = 1'b1;
                n_st   = S_VEM;
            end
            S_VEM: begin
                if (ofree) begin
                    o_load   = 1'b1;
                    ld_found = 1'b1;
                    ld_byte  = r_val_q;
                    ld_bvld  = 1'b1;
                    // exactly "0" reads as false
                    ld_bool  = (r_vj == '0)
                             ? !(r_vlen_q == VLW'(1) && r_val_q == C_ZERO) : r_bv;
                    n_bv     = ld_bool;
                    ld_last  = (r_vj + VLW'(1) == r_vlen_q);
                    if (ld_last) begin
                        n_st = S_IDLE;
                    end else begin
                        n_vj = r_vj + VLW'(1);
                        n_st = S_VRD;
                    end
                end
            end
            S_SINGLE: begin
                if (ofree) begin
                    o_load = 1'b1;
                    n_st   = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (kwe) begin
            key_mem[kw_addr] <= i_data_byte;
        end
        if (key_re) begin
            r_key_q <= key_mem[KAW'(r_kbase + KAW'(r_j))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            val_mem[vw_addr] <= v_data;
        end
        if (val_re) begin
            r_val_q <= val_mem[VAW'(r_vbase + VAW'(r_vj))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lwe) begin
            klen_mem[s_np[IW-1:0]] <= cm_kl;
            vlen_mem[s_np[IW-1:0]] <= cm_vl;
        end
        if (len_re) begin
            r_klen_q <= klen_mem[r_ei[IW-1:0]];
            r_vlen_q <= vlen_mem[r_ei[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qwe) begin
            qbuf_mem[q_base[QIW-1:0]] <= i_data_byte;
        end
        if (key_re) begin
            r_qb_q <= qbuf_mem[r_j[QIW-1:0]];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph      <= PH_DONE;
            r_kl      <= '0;
            r_vl      <= '0;
            r_np      <= '0;
            r_lbs     <= '0;
            r_qlen    <= '0;
            r_qclosed <= 1'b0;
            r_st      <= S_IDLE;
            r_ov      <= 1'b0;
        end else begin
            r_ph      <= n_ph;
            r_kl      <= n_kl;
            r_vl      <= n_vl;
            r_np      <= n_np;
            r_lbs     <= n_lbs;
            r_qlen    <= n_qlen;
            r_qclosed <= n_qclosed;
            r_st      <= n_st;
            if (o_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ei    <= n_ei;
        r_kbase <= n_kbase;
        r_vbase <= n_vbase;
        r_j     <= n_j;
        r_vj    <= n_vj;
        r_hit   <= n_hit;
        r_bv    <= n_bv;
        if (o_load) begin
            r_found <= ld_found;
            r_vbyte <= ld_byte;
            r_bvld  <= ld_bvld;
            r_bool  <= ld_bool;
            r_last  <= ld_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_found       = r_found;
    assign o_value_byte  = r_vbyte;
    assign o_byte_valid  = r_bvld;
    assign o_bool_value  = r_bool;
    assign o_last_result = r_last;

    // ---------------- assertions ----------------
    a_np_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_np <= EW'(MAX_ENTRIES))
        else $error("stored pair count above table size");

    a_qlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= KLW'(MAX_KEY))
        else $error("query length above limit");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_found) |-> (!r_bvld && !r_bool && r_last))
        else $error("miss result carries data");

    a_lk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LEN && $past(r_st) == S_IDLE) |->
            $past(in_acc && i_opcode == OP_QUERY && i_last_byte))
        else $error("lookup began without a closing query item");

    a_no_write_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> (!kwe && !lwe && !qwe))
        else $error("table written during lookup");

endmodule : key_value_line_parser_lookup_unit
`default_nettype wire

[bench/kvlp_checker.sv]
// ----------------------------------------------------------------------------
// kvlp_checker
// Watches both channels of the key/value line parser, keeps its own model of
// the parse table and the query key, and compares every result item in order.
// ----------------------------------------------------------------------------
module kvlp_checker #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_KEY     = 32,
    parameter int MAX_VALUE   = 64,
    parameter int LINE_BUF    = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic       i_found,
    input  wire logic [7:0] i_value_byte,
    input  wire logic       i_byte_valid,
    input  wire logic       i_bool_value,
    input  wire logic       i_last_result,
    output int              o_fail_count,
    output int              o_pending
);
    import kvlp_pkg::*;

    typedef struct packed {
        logic       found;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       bool_value;
        logic       last_result;
    } t_answer;

    logic [7:0] keys   [MAX_ENTRIES][MAX_KEY];
    logic [7:0] values [MAX_ENTRIES][MAX_VALUE];
    int         key_len [MAX_ENTRIES];
    int         val_len [MAX_ENTRIES];
    int         n_pairs;
    t_phase     phase;
    int         tok_key_len;
    int         tok_val_len;
    int         line_count;
    logic [7:0] qkey [MAX_KEY];
    int         qlen;
    bit         qclosed;
    t_answer    answers_due [$];

    function automatic bit is_blank(logic [7:0] c);
        return c == C_SPACE || c == C_TAB;
    endfunction

    function automatic void push_key(logic [7:0] c);
        if (tok_key_len < MAX_KEY - 1) begin
            if (n_pairs < MAX_ENTRIES) keys[n_pairs][tok_key_len] = c;
            tok_key_len++;
        end
    endfunction

    function automatic void push_value(logic [7:0] c);
        if (tok_val_len < MAX_VALUE - 1) begin
            if (n_pairs < MAX_ENTRIES) values[n_pairs][tok_val_len] = c;
            tok_val_len++;
        end
    endfunction

    function automatic void close_token();
        if (phase == PH_KEY) begin
            tok_val_len = 0;
            push_value(C_ONE);
        end
        if ((phase == PH_KEY || phase == PH_VAL) && tok_key_len > 0
                && n_pairs < MAX_ENTRIES) begin
            key_len[n_pairs] = tok_key_len;
            val_len[n_pairs] = tok_val_len;
            n_pairs++;
        end
    endfunction

    function automatic void tokenize(logic [7:0] c);
        case (phase)
            PH_GAP: begin
                if (!is_blank(c)) begin
                    tok_key_len = 0;
                    tok_val_len = 0;
                    if (c == C_EQ) begin
                        phase = PH_VAL;
                    end else begin
                        phase = PH_KEY;
                        push_key(c);
                    end
                end
            end
            PH_KEY: begin
                if (is_blank(c)) begin
                    close_token();
                    phase = PH_GAP;
                end else if (c == C_EQ) begin
                    phase = PH_VAL;
                    tok_val_len = 0;
                end else begin
                    push_key(c);
                end
            end
            PH_VAL: begin
                if (is_blank(c)) begin
                    close_token();
                    phase = PH_GAP;
                end else begin
                    push_value(c);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_lookup();
        int      hit;
        bit      same;
        bit      truthy;
        t_answer a;
        hit = -1;
        for (int i = 0; i < n_pairs && hit < 0; i++) begin
            if (key_len[i] == qlen && qlen < MAX_KEY) begin
                same = 1;
                for (int j = 0; j < qlen; j++)
                    if (keys[i][j] != qkey[j]) same = 0;
                if (same) hit = i;
            end
        end
        if (hit < 0) begin
            a = '{found: 0, value_byte: 8'h00, byte_valid: 0, bool_value: 0,
                  last_result: 1};
            answers_due.push_back(a);
            return;
        end
        truthy = !(val_len[hit] == 1 && values[hit][0] == C_ZERO);
        if (val_len[hit] == 0) begin
            a = '{found: 1, value_byte: 8'h00, byte_valid: 0, bool_value: truthy,
                  last_result: 1};
            answers_due.push_back(a);
            return;
        end
        for (int j = 0; j < val_len[hit]; j++) begin
            a = '{found: 1, value_byte: values[hit][j], byte_valid: 1,
                  bool_value: truthy, last_result: (j + 1 == val_len[hit])};
            answers_due.push_back(a);
        end
    endfunction

    function automatic void take_item(logic op, logic [7:0] c, logic first, logic last);
        if (op == OP_LINE) begin
            if (first) begin
                n_pairs = 0;
                line_count = 0;
                tok_key_len = 0;
                tok_val_len = 0;
                phase = PH_GAP;
            end
            if (phase == PH_DONE) return;
            if (c == C_NUL) begin
                close_token();
                phase = PH_DONE;
                return;
            end
            tokenize(c);
            line_count++;
            if (last || line_count >= LINE_BUF - 1) begin
                close_token();
                phase = PH_DONE;
            end
            return;
        end
        if (first) begin
            qlen = 0;
            qclosed = 0;
        end
        if (!qclosed) begin
            if (c == C_NUL) qclosed = 1;
            else if (qlen < MAX_KEY - 1) begin
                qkey[qlen] = c;
                qlen++;
            end else qlen = MAX_KEY;
        end
        if (last) predict_lookup();
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            n_pairs <= 0;
            phase <= PH_DONE;
            tok_key_len <= 0;
            tok_val_len <= 0;
            line_count <= 0;
            qlen <= 0;
            qclosed <= 0;
            o_fail_count <= 0;
            o_pending <= 0;
            answers_due.delete();
        end else begin
            // output first: a result can never come from this edge's input item
            if (i_out_valid && !i_out_stall) begin
                got = '{i_found, i_value_byte, i_byte_valid, i_bool_value, i_last_result};
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result item %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                take_item(i_opcode, i_data_byte, i_first_byte, i_last_byte);
            o_pending <= answers_due.size();
        end
    end

endmodule : kvlp_checker

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives command lines and key queries into the key/value line parser with
// random gaps and stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb;
    import kvlp_pkg::*;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    logic       opcode = OP_LINE;
    logic [7:0] data_byte = 8'h00;
    logic       first_byte = 0;
    logic       last_byte = 0;
    logic       out_valid;
    logic       out_stall = 0;
    logic       found;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       bool_value;
    logic       last_result;
    int         fail_count;
    int         pending;
    bit         hold_long = 0;
    bit         stim_done = 0;

    typedef struct {
        logic       op;
        logic [7:0] c;
        logic       first;
        logic       last;
    } t_byte_item;

    t_byte_item feed [$];

    always #5 i_clk = ~i_clk;

    key_value_line_parser_lookup_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_data_byte(data_byte),
        .i_first_byte(first_byte), .i_last_byte(last_byte),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_found(found), .o_value_byte(value_byte), .o_byte_valid(byte_valid),
        .o_bool_value(bool_value), .o_last_result(last_result)
    );

    kvlp_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_data_byte(data_byte),
        .i_first_byte(first_byte), .i_last_byte(last_byte),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_found(found), .i_value_byte(value_byte), .i_byte_valid(byte_valid),
        .i_bool_value(bool_value), .i_last_result(last_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic void add(logic op, logic [7:0] c, logic first, logic last);
        t_byte_item it;
        it = '{op, c, first, last};
        feed.push_back(it);
    endfunction

    function automatic void add_string(logic op, string s, bit with_last);
        for (int i = 0; i < s.len(); i++)
            add(op, s[i], i == 0, with_last && i == s.len() - 1);
    endfunction

    // small alphabet so keys collide and queries hit
    function automatic logic [7:0] key_char();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return "c";
            default: return "0";
        endcase
    endfunction

    function automatic void random_line();
        int ntok;
        bit first;
        first = 1;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            int kl;
            kl = $urandom_range(0, 3);
            for (int i = 0; i < kl; i++) begin
                add(OP_LINE, key_char(), first, 0);
                first = 0;
            end
            if ($urandom_range(0, 2) != 0) begin
                add(OP_LINE, C_EQ, first, 0);
                first = 0;
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    add(OP_LINE, $urandom_range(0, 5) == 0 ? 8'($urandom) | 8'h80
                        : key_char(), 0, 0);
            end
            add(OP_LINE, $urandom_range(0, 1) ? C_SPACE : C_TAB, first, 0);
            first = 0;
        end
        case ($urandom_range(0, 2))
            0: add(OP_LINE, C_NUL, 0, 0);
            1: add(OP_LINE, key_char(), 0, 1);
            default: add(OP_LINE, C_NUL, 0, 1);
        endcase
    endfunction

    function automatic void random_query();
        int kl;
        kl = $urandom_range(1, 3);
        for (int i = 0; i < kl; i++)
            add(OP_QUERY, $urandom_range(0, 9) == 0 ? 8'($urandom) : key_char(),
                i == 0, i == kl - 1);
    endfunction

    initial begin
        string s;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed part
        add_string(OP_QUERY, "a", 1);                 // lookup on an empty table
        add(OP_LINE, "x", 0, 0);                      // ignored, no parse active
        add_string(OP_LINE, "k=0 \tf =v =z ab=", 0);  // "0", flag, empty key, empty value
        add(OP_LINE, C_NUL, 0, 1);
        add_string(OP_QUERY, "k", 1);
        add_string(OP_QUERY, "f", 1);
        add_string(OP_QUERY, "ab", 1);
        add(OP_QUERY, "a", 1, 0);                     // zero ends the key, rest ignored
        add(OP_QUERY, C_NUL, 0, 0);
        add(OP_QUERY, "b", 0, 1);
        add(OP_QUERY, "b", 0, 1);                     // ignored, held key "a" stays closed
        feed.push_back('{OP_LINE, "q", 1, 0});        // restart: a new line clears the table
        add_string(OP_LINE, "r=", 0);
        add(OP_LINE, 8'hFF, 0, 1);
        add_string(OP_QUERY, "r", 1);
        add_string(OP_QUERY, "q", 1);

        // long key and long value are truncated; one more query byte is too long
        for (int i = 0; i < 33; i++) add(OP_LINE, "k", i == 0, 0);
        add(OP_LINE, C_EQ, 0, 0);
        for (int i = 0; i < 64; i++) add(OP_LINE, 8'(8'h30 + i), 0, i == 63);
        for (int i = 0; i < 31; i++) add(OP_QUERY, "k", i == 0, i == 30);
        add(OP_QUERY, "k", 0, 1);
        // table overflow: 18 pairs, only 16 kept
        s = "";
        for (int i = 0; i < 18; i++) s = {s, string'(8'("A" + i)), " "};
        add_string(OP_LINE, s, 1);
        add_string(OP_QUERY, "P", 1);
        add_string(OP_QUERY, "Q", 1);

        while (feed.size() < 225) begin
            int pick;
            pick = $urandom_range(0, 9);
            if (pick < 3) random_line();
            else if (pick < 9) random_query();
            else add(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end

        while (feed.size() > 0) begin
            t_byte_item it;
            it = feed.pop_front();
            repeat ($urandom_range(0, 4) * $urandom_range(0, 1)) begin
                in_valid <= 0;
                @(negedge i_clk);
            end
            in_valid <= 1;
            opcode <= it.op;
            data_byte <= it.c;
            first_byte <= it.first;
            last_byte <= it.last;
            // stall is registered, so its value here holds at the next rising edge
            while (in_stall) @(negedge i_clk);
            @(negedge i_clk);
        end
        in_valid <= 0;
        stim_done = 1;
    end

    // receiver: random stalls, and one long hold that backs up the block
    initial begin
        int held;
        int wait_cycles;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_long && held == 0 && pending > 10) begin
                hold_long = 1;
                out_stall <= 1;
                repeat (300) @(negedge i_clk);
                out_stall <= 0;
                held = 1;
            end else begin
                wait_cycles = $urandom_range(0, 4);
                if (wait_cycles > 0) begin
                    out_stall <= 1;
                    repeat (wait_cycles) @(negedge i_clk);
                    out_stall <= 0;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule : tb
